// ===== src/assert_macros.svh =====
// Assertion helper macros for the path turn and length accumulator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ptla_pkg.sv =====
// Types, constants and helper functions for the path turn and length accumulator.
// No dependencies; imported by path_turn_length_accumulator.
`default_nettype none

package ptla_pkg;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [15:0] t_angle;
    typedef logic        [39:0] t_len;
    typedef logic        [31:0] t_turn;

    // CORDIC datapath widths
    localparam int X_W = 44;   // |d| * 256 with CORDIC gain and sqrt(2) headroom
    localparam int Z_W = 35;   // accumulated angle, 2^-30 rad, plus a pi offset
    localparam int D_W = 18;   // angle differences before wrapping

    localparam logic signed [D_W-1:0] PI_Q12     = 18'sd12868;
    localparam logic signed [D_W-1:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic signed [Z_W-1:0] PI_Q30     = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] ANG_RND    = 35'sd131072;
    localparam logic signed [Z_W-1:0] ANG_MAX    = 35'sd12868;
    localparam logic signed [Z_W-1:0] ANG_MIN    = -35'sd12868;
    localparam logic        [31:0]    INV_GAIN_Q32 = 32'h9B74EDA8;
    localparam logic        [39:0]    LEN_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic        [31:0]    TURN_MAX   = 32'hFFFF_FFFF;

    // arctan(2^-i) in units of 2^-30 rad, truncated
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
        30'h00000000, 30'h00000000
    };

    // Wrap an angle difference into [-pi, pi] and return its magnitude.
    // Differences stay within +-2^16, so three steps of 2*pi suffice.
    function automatic logic [15:0] wrap_abs(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] v;
        v = d;
        for (int k = 0; k < 3; k++) begin
            if (v > PI_Q12) begin
                v = v - TWO_PI_Q12;
            end else if (v < -PI_Q12) begin
                v = v + TWO_PI_Q12;
            end
        end
        return (v < 0) ? 16'(-v) : 16'(v);
    endfunction

endpackage

`default_nettype wire

// ===== src/path_turn_length_accumulator.sv =====
// Path turn and length accumulator: top level with its CORDIC sequencer.
// Depends on ptla_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one waypoint per transfer:
//   i_new_plan, i_pos_x, i_pos_y (Q16.16) and i_heading (Q3.12).
//   Output channel (o_valid / i_ready) returns exactly one result per
//   waypoint: the waypoint echoed plus running path length, tangent turn
//   and heading turn totals, all including the current point.
//   Sequence: a waypoint that starts a plan (or the first after reset) goes
//   straight to the update; any other waypoint passes through load, one
//   micro-rotation per cycle on the shared add/shift unit, two passes through
//   one shared 32x32 multiplier, round, update.
//   A new waypoint is taken only once the last one has passed its update;
//   o_ready is high only while the sequencer is idle.
//   The result sits in an output register, so the next waypoint is taken
//   while a finished result still waits; a stalled receiver (i_ready low)
//   holds the result and the next item waits before its final update.
//   Reset (i_rst_n low, synchronous) clears all sums and the stored point.
`default_nettype none

module path_turn_length_accumulator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_new_plan,
    input  ptla_pkg::t_coord i_pos_x,
    input  ptla_pkg::t_coord i_pos_y,
    input  ptla_pkg::t_angle i_heading,
    output logic             o_valid,
    input  logic             i_ready,
    output ptla_pkg::t_coord o_echo_x,
    output ptla_pkg::t_coord o_echo_y,
    output ptla_pkg::t_angle o_echo_heading,
    output ptla_pkg::t_len   o_path_length,
    output ptla_pkg::t_turn  o_tangent_turn,
    output ptla_pkg::t_turn  o_heading_turn
);
    import ptla_pkg::*;

`include "assert_macros.svh"

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ITER  = 3'd2;
    localparam logic [2:0] S_MULHI = 3'd3;
    localparam logic [2:0] S_MULLO = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // Captured waypoint and segment deltas
    logic              r_restart;
    t_coord            r_px, r_py;
    t_angle            r_hd;
    logic signed [32:0] r_dx, r_dy;
    logic              r_dx_neg, r_dy_zero, r_dy_pos;

    // CORDIC working registers
    logic signed [X_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0] r_cz;

    // Gain correction and per-item contributions
    logic [59:0]  r_prod_hi;
    logic [47:0]  r_prod_lo;
    t_angle       r_ang;
    logic [39:0]  r_mag;
    logic [15:0]  r_tdiff, r_hdiff;

    // Architectural state; the echo outputs are the stored point itself
    t_coord       r_last_x, r_last_y;
    t_angle       r_last_heading, r_last_tangent;
    logic         r_tan_known, r_have_point;
    t_len         r_len_sum;
    t_turn        r_tan_sum, r_hdg_sum;
    logic         r_out_valid;

    logic in_xfer, out_xfer, slot_free, fin_go;

    assign o_ready   = (r_state == S_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign out_xfer  = r_out_valid && i_ready;
    // Output register can take a new result when empty or drained this cycle
    assign slot_free = !r_out_valid || i_ready;
    assign fin_go    = (r_state == S_FIN) && slot_free;

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    // Plan start or first point needs no CORDIC pass: jump to the update
                    n_state = (i_new_plan || !r_have_point) ? S_FIN : S_LOAD;
                end
            end
            S_LOAD: begin
                n_step  = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_MULHI;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MULHI: n_state = S_MULLO;
            S_MULLO: n_state = S_ROUND;
            S_ROUND: n_state = S_FIN;
            S_FIN: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    //------------------------------------------------------------------
    // Shared CORDIC add/shift unit: one micro-rotation per cycle
    //------------------------------------------------------------------
    logic signed [X_W-1:0] xs, ys;
    logic signed [Z_W-1:0] atan_step;
    logic signed [33:0]    ld_ax, ld_ay;

    assign xs        = r_cx >>> r_step;
    assign ys        = r_cy >>> r_step;
    assign atan_step = $signed({5'b0, ATAN_Q30[5'(r_step)]});

    // Fold the left half-plane onto the right one: negate both deltas
    assign ld_ax = r_dx[32] ? -34'(r_dx) : 34'(r_dx);
    assign ld_ay = r_dx[32] ? -34'(r_dy) : 34'(r_dy);

    //------------------------------------------------------------------
    // Shared 32x32 multiplier: high then low part of the magnitude
    //------------------------------------------------------------------
    logic [31:0] mul_a;
    logic [63:0] mul_p;

    assign mul_a = (r_state == S_MULHI) ? {4'b0, r_cx[X_W-1:16]} : {16'b0, r_cx[15:0]};
    assign mul_p = {32'b0, mul_a} * {32'b0, INV_GAIN_Q32};

    // Angle rounding to Q3.12 with clamp to [-pi, pi]
    logic signed [Z_W-1:0] z_rnd;
    logic signed [Z_W-1:0] z_clamped;
    always_comb begin
        z_rnd = (r_cz + ANG_RND) >>> 18;
        if (z_rnd > ANG_MAX) begin
            z_clamped = ANG_MAX;
        end else if (z_rnd < ANG_MIN) begin
            z_clamped = ANG_MIN;
        end else begin
            z_clamped = z_rnd;
        end
    end

    logic [59:0] mag_sum;
    assign mag_sum = r_prod_hi + 60'(r_prod_lo[47:16]) + 60'(24'h80_0000);

    //------------------------------------------------------------------
    // Datapath
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_restart <= i_new_plan || !r_have_point;
                    r_px      <= i_pos_x;
                    r_py      <= i_pos_y;
                    r_hd      <= i_heading;
                    r_dx      <= 33'(i_pos_x) - 33'(r_last_x);
                    r_dy      <= 33'(i_pos_y) - 33'(r_last_y);
                end
            end
            S_LOAD: begin
                // Scale by 256 for guard bits
                r_cx      <= X_W'(ld_ax) <<< 8;
                r_cy      <= X_W'(ld_ay) <<< 8;
                r_cz      <= '0;
                r_dx_neg  <= r_dx[32];
                r_dy_zero <= (r_dy == '0);
                r_dy_pos  <= !r_dy[32] && (r_dy != '0);
            end
            S_ITER: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_step;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_step;
                end
            end
            S_MULHI: begin
                r_prod_hi <= mul_p[59:0];
                // Undo the half-plane fold
                if (r_dx_neg) begin
                    r_cz <= r_dy_pos ? (r_cz + PI_Q30) : (r_cz - PI_Q30);
                end
            end
            S_MULLO: begin
                r_prod_lo <= mul_p[47:0];
                if (r_dy_zero) begin
                    // Along the x axis, including the zero-length segment
                    r_ang <= r_dx_neg ? 16'(PI_Q12) : '0;
                end else begin
                    r_ang <= 16'(z_clamped);
                end
            end
            S_ROUND: begin
                r_mag   <= 40'(mag_sum[59:24]);
                r_tdiff <= wrap_abs(D_W'(r_ang) - D_W'(r_last_tangent));
                r_hdiff <= wrap_abs(D_W'(r_hd) - D_W'(r_last_heading));
            end
            default: begin
            end
        endcase
    end

    //------------------------------------------------------------------
    // Running sums, stored point and output register
    //------------------------------------------------------------------
    logic [40:0] len_add;
    logic [32:0] tan_add, hdg_add;

    assign len_add = {1'b0, r_len_sum} + {1'b0, r_mag};
    assign tan_add = {1'b0, r_tan_sum} + {17'b0, r_tdiff};
    assign hdg_add = {1'b0, r_hdg_sum} + {17'b0, r_hdiff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_last_heading <= '0;
            r_last_tangent <= '0;
            r_tan_known    <= 1'b0;
            r_have_point   <= 1'b0;
            r_len_sum      <= '0;
            r_tan_sum      <= '0;
            r_hdg_sum      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid    <= 1'b1;
                r_last_x       <= r_px;
                r_last_y       <= r_py;
                r_last_heading <= r_hd;
                if (r_restart) begin
                    // Plan start: clear sums, no contribution
                    r_len_sum      <= '0;
                    r_tan_sum      <= '0;
                    r_hdg_sum      <= '0;
                    r_tan_known    <= 1'b0;
                    r_last_tangent <= '0;
                    r_have_point   <= 1'b1;
                end else begin
                    r_len_sum <= len_add[40] ? LEN_MAX : len_add[39:0];
                    r_hdg_sum <= hdg_add[32] ? TURN_MAX : hdg_add[31:0];
                    if (r_tan_known) begin
                        r_tan_sum <= tan_add[32] ? TURN_MAX : tan_add[31:0];
                    end
                    r_last_tangent <= r_ang;
                    r_tan_known    <= 1'b1;
                end
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_echo_x       = r_last_x;
    assign o_echo_y       = r_last_y;
    assign o_echo_heading = r_last_heading;
    assign o_path_length  = r_len_sum;
    assign o_tangent_turn = r_tan_sum;
    assign o_heading_turn = r_hdg_sum;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    `ASSERT_NEXT(a_fin_posts_result, i_clk, i_rst_n, fin_go, o_valid, "result not posted after update")
    `ASSERT_NEXT(a_tan_zero_until_known, i_clk, i_rst_n, fin_go && !r_tan_known, o_tangent_turn == '0, "tangent sum moved before a tangent was known")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_xfer, !o_ready, "input ready while an item is in progress")

endmodule

`default_nettype wire
